### src/afr_pkg.sv
// afr_pkg: shared types and constants of the addressed stx/etx frame receiver
// no dependencies; used by the mode fsm and the top level

package afr_pkg;

  localparam logic [7:0] ChStx = 8'h02;
  localparam logic [7:0] ChEtx = 8'h03;
  localparam logic [7:0] ChDle = 8'h10;

  localparam int unsigned PosWidth = 6;
  localparam int unsigned LenWidth = 7;

  typedef enum logic [2:0] {
    MODE_HUNT,
    MODE_SKIP,
    MODE_ADDRESS,
    MODE_DATA,
    MODE_ESCAPED
  } rx_mode_e;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] node_address;
  } cfg_item_t;

  typedef struct packed {
    logic                kind;
    logic [7:0]          data_byte;
    logic [PosWidth-1:0] position;
    logic [LenWidth-1:0] frame_length;
    logic                overflow;
  } result_item_t;

  // one processed byte: whether it yields a beat, and the beat itself
  typedef struct packed {
    logic         valid;
    result_item_t item;
  } step_result_t;

endpackage

### src/afr_stream_if.sv
// afr_stream_if: valid/ready channel carrying one payload per beat
// payload type is set per instance from afr_pkg types

interface afr_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### src/afr_fsm.sv
// afr_fsm: receive mode state machine, byte counter and overflow flag
// depends on afr_pkg; advances one byte each cycle that step_i is high

module afr_fsm
  import afr_pkg::*;
#(
  parameter int unsigned Depth = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   rx_byte_i,
  input  logic [7:0]   node_address_i,
  output step_result_t result_o
);

  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam int unsigned ExtWidth = (CntWidth > LenWidth) ? CntWidth : LenWidth;

  rx_mode_e              mode_q, mode_d;
  logic [CntWidth-1:0]   count_q, count_d;
  logic                  ovf_q, ovf_d;
  logic [ExtWidth-1:0]   count_ext;
  logic                  store;
  logic                  full;

  assign count_ext = ExtWidth'(count_q);
  assign full      = (count_q == CntWidth'(Depth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_HUNT;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    store    = 1'b0;
    result_o = '0;
    unique case (mode_q)
      MODE_SKIP: begin
        mode_d = MODE_HUNT;
      end
      MODE_ADDRESS: begin
        if (rx_byte_i == node_address_i) begin
          mode_d  = MODE_DATA;
          count_d = '0;
          ovf_d   = 1'b0;
        end else begin
          mode_d = MODE_HUNT;
        end
      end
      MODE_DATA: begin
        priority if (rx_byte_i == ChEtx) begin
          mode_d                     = MODE_HUNT;
          result_o.valid             = 1'b1;
          result_o.item.kind         = KIND_END;
          result_o.item.frame_length = count_ext[LenWidth-1:0];
          result_o.item.overflow     = ovf_q;
        end else if (rx_byte_i == ChDle) begin
          mode_d = MODE_ESCAPED;
        end else begin
          store = 1'b1;
        end
      end
      MODE_ESCAPED: begin
        mode_d = MODE_DATA;
        store  = 1'b1;
      end
      default: begin
        priority if (rx_byte_i == ChStx) begin
          mode_d = MODE_ADDRESS;
        end else if (rx_byte_i == ChDle) begin
          mode_d = MODE_SKIP;
        end else begin
          mode_d = MODE_HUNT;
        end
      end
    endcase

    // data byte: emit with its position, or drop once the frame is full
    if (store) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d                 = count_q + CntWidth'(1);
        result_o.valid          = 1'b1;
        result_o.item.kind      = KIND_DATA;
        result_o.item.data_byte = rx_byte_i;
        result_o.item.position  = count_ext[PosWidth-1:0];
      end
    end
  end

endmodule

### src/addressed_stx_etx_frame_receiver_unit.sv
// addressed_stx_etx_frame_receiver_unit: top level of the frame receiver
// depends on afr_pkg, afr_stream_if and afr_fsm
//
// usage: rx_i takes one received byte per beat. frames look like
// STX, address, data..., ETX, with DLE escaping the next data byte; a DLE
// while hunting skips one byte. only frames whose address byte equals the
// node address written on cfg_i are received. res_o gives one beat per
// stored data byte (kind 0, with its position) and one at ETX (kind 1,
// frame length and overflow flag). bytes beyond Depth in a frame are
// dropped and flagged in the end beat.
// timing: a byte is registered on acceptance, then decoded and its result
// registered, so each result beat has passed the input register and the
// result register. one byte per cycle is sustained while res_o is
// ready; the input and result registers sit on either side of the mode fsm.
// stall: when res_o is held off, the result register holds, the input
// register fills and then rx_i ready drops; nothing is lost.
// reset: hunting for STX, count and overflow cleared, node address zero.
// cfg_i is always ready; write it only while no frame bytes are in flight.

module addressed_stx_etx_frame_receiver_unit
  import afr_pkg::*;
#(
  parameter int unsigned Depth = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  afr_stream_if.sink   rx_i,
  afr_stream_if.sink   cfg_i,
  afr_stream_if.source res_o
);

  logic [7:0]   node_address_q;
  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         out_valid_q;
  result_item_t out_item_q;
  logic         out_free;
  logic         step;
  step_result_t step_res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_address_q <= '0;
    end else if (cfg_i.valid) begin
      node_address_q <= cfg_i.payload.node_address;
    end
  end

  // decoded byte may move on when the result register is empty or draining
  assign out_free   = !out_valid_q || res_o.ready;
  assign step       = in_valid_q && out_free;
  assign rx_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.payload.rx_byte;
    end
  end

  afr_fsm #(
    .Depth(Depth)
  ) u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .rx_byte_i     (in_byte_q),
    .node_address_i(node_address_q),
    .result_o      (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && step_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step && step_res.valid) begin
      out_item_q <= step_res.item;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_item_q;

endmodule
